/* rtl/pwfd_pkg.sv */
package pwfd_pkg;

    // Frame geometry
    localparam int FRAME_BITS = 72;
    localparam int BIT_CNT_W  = 8;
    localparam int IDX_W      = 5;

    // Configuration register layout
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int QUIET_W    = 24;
    localparam int DELAY_W    = 16;
    localparam int SKIP_W     = 24;
    localparam int COUNT_W    = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_QUIET_LEN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_DELAY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_LEN     = 2'd2;

    localparam logic [QUIET_W-1:0] QUIET_RST = 24'd19000;
    localparam logic [DELAY_W-1:0] DELAY_RST = 16'd2000;
    localparam logic [SKIP_W-1:0]  SKIP_RST  = 24'd1000000;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QAW         = $clog2(QUEUE_DEPTH);

    // One classified line sample
    typedef struct packed {
        logic level;
        logic edge_seen;
    } t_sample;

    // Queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

/* rtl/pwfd_front.sv */
module pwfd_front
    import pwfd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  logic      i_level,
    input  t_q_status i_q_status,
    output logic      o_push,
    output t_sample   o_item,
    output logic      o_stall
);

    logic r_prev_level;

    // Accept whenever the queue has room
    assign o_stall = i_q_status.full;
    assign o_push  = i_valid && !i_q_status.full;

    // Classify the sample against the previous one
    assign o_item.level     = i_level;
    assign o_item.edge_seen = (i_level != r_prev_level);

    // Track the previous accepted level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_level <= 1'b0;
        end else if (o_push) begin
            r_prev_level <= i_level;
        end
    end

endmodule

/* rtl/pwfd_queue.sv */
module pwfd_queue
    import pwfd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_sample   i_item,
    input  logic      i_pop,
    output t_sample   o_item,
    output t_q_status o_status
);

    t_sample          r_mem [QUEUE_DEPTH];
    logic [QAW-1:0]   r_wr_ptr;
    logic [QAW-1:0]   r_rd_ptr;
    logic [QAW:0]     r_count;

    assign o_item          = r_mem[r_rd_ptr];
    assign o_status.full   = (r_count == (QAW+1)'(QUEUE_DEPTH));
    assign o_status.empty  = (r_count == '0);

    // Store incoming items
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* rtl/pwfd_back.sv */
module pwfd_back
    import pwfd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_sample               i_item,
    input  t_q_status             i_q_status,
    output logic                  o_pop,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [7:0]            o_data_byte,
    output logic [IDX_W-1:0]      o_byte_index,
    output logic                  o_last_byte
);

    localparam logic [2:0] PH_INIT       = 3'd0;
    localparam logic [2:0] PH_INIT_FALL  = 3'd1;
    localparam logic [2:0] PH_WAIT_EDGE  = 3'd2;
    localparam logic [2:0] PH_WINDOW     = 3'd3;
    localparam logic [2:0] PH_SKIP       = 3'd4;
    localparam logic [2:0] PH_START_FALL = 3'd5;
    localparam logic [2:0] PH_DELAY      = 3'd6;
    localparam logic [2:0] PH_EDGES      = 3'd7;

    logic [QUIET_W-1:0]   r_quiet_len;
    logic [DELAY_W-1:0]   r_sample_delay;
    logic [SKIP_W-1:0]    r_skip_len;

    logic [2:0]           r_phase,    n_phase;
    logic [COUNT_W-1:0]   r_count,    n_count;
    logic                 r_ewin,     n_ewin;
    logic [1:0]           r_pend,     n_pend;
    logic [7:0]           r_shift,    n_shift;
    logic [BIT_CNT_W-1:0] r_bits,     n_bits;

    logic                 r_out_valid;
    logic [7:0]           r_data_byte;
    logic [IDX_W-1:0]     r_byte_index;
    logic                 r_last_byte;

    logic                 out_free;
    logic                 step;
    logic                 emit;
    logic                 lvl;
    logic                 edge_seen;
    logic                 ew;
    logic [COUNT_W-1:0]   cnt_inc;
    logic [BIT_CNT_W:0]   bits_next;
    logic [BIT_CNT_W+1:0] bits_plus9;
    logic [7:0]           shift_base;

    // Set the bit for a low sample at the given position
    function automatic logic [7:0] bit_mask(input logic [2:0] pos, input logic level);
        logic [7:0] m;
        m = 8'h80 >> pos;
        return level ? 8'h00 : m;
    endfunction

    // Step only when a sample waits and the result register can take a byte
    assign out_free  = !r_out_valid || !i_out_stall;
    assign step      = !i_q_status.empty && out_free;
    assign o_pop     = step;
    assign lvl       = i_item.level;
    assign edge_seen = i_item.edge_seen;
    assign cnt_inc   = r_count + 1'b1;
    assign bits_next = {1'b0, r_bits} + 1'b1;
    assign bits_plus9 = {2'b00, r_bits} + (BIT_CNT_W+2)'(9);

    // Next-state logic of the frame sequencer
    always_comb begin
        n_phase    = r_phase;
        n_count    = r_count;
        n_ewin     = r_ewin;
        n_pend     = r_pend;
        n_shift    = r_shift;
        n_bits     = r_bits;
        emit       = 1'b0;
        ew         = r_ewin | edge_seen;
        shift_base = r_shift;
        if (step) begin
            unique case (r_phase)
                PH_INIT: begin
                    n_phase = lvl ? PH_INIT_FALL : PH_WAIT_EDGE;
                end
                PH_INIT_FALL: begin
                    if (edge_seen) begin
                        n_phase = PH_WAIT_EDGE;
                    end
                end
                PH_WAIT_EDGE: begin
                    if (edge_seen) begin
                        n_count = '0;
                        n_ewin  = 1'b0;
                        if (r_quiet_len == '0) begin
                            n_phase = lvl ? PH_START_FALL : PH_WAIT_EDGE;
                        end else begin
                            n_phase = PH_WINDOW;
                        end
                    end
                end
                PH_WINDOW: begin
                    n_count = cnt_inc;
                    n_ewin  = ew;
                    if (cnt_inc >= r_quiet_len) begin
                        if (ew) begin
                            if (r_skip_len == '0) begin
                                n_phase = PH_WAIT_EDGE;
                            end else begin
                                n_phase = PH_SKIP;
                                n_count = '0;
                            end
                        end else begin
                            n_phase = lvl ? PH_START_FALL : PH_WAIT_EDGE;
                        end
                    end
                end
                PH_SKIP: begin
                    n_count = cnt_inc;
                    if (cnt_inc >= r_skip_len) begin
                        n_phase = PH_WAIT_EDGE;
                    end
                end
                PH_START_FALL: begin
                    if (edge_seen) begin
                        n_bits  = '0;
                        n_shift = '0;
                        n_count = '0;
                        if (r_sample_delay == '0) begin
                            n_shift = bit_mask(3'd0, lvl);
                            n_pend  = lvl ? 2'd1 : 2'd2;
                            n_phase = PH_EDGES;
                        end else begin
                            n_phase = PH_DELAY;
                        end
                    end
                end
                PH_DELAY: begin
                    n_count = cnt_inc;
                    if (cnt_inc >= {8'h00, r_sample_delay}) begin
                        n_shift = r_shift | bit_mask(r_bits[2:0], lvl);
                        n_pend  = lvl ? 2'd1 : 2'd2;
                        n_phase = PH_EDGES;
                    end
                end
                PH_EDGES: begin
                    if (edge_seen && r_pend != 2'd0) begin
                        n_pend = r_pend - 1'b1;
                        if (r_pend == 2'd1) begin
                            // Emit a byte after each eighth bit
                            if (r_bits[2:0] == 3'd7) begin
                                emit       = 1'b1;
                                shift_base = '0;
                                n_shift    = '0;
                            end
                            if (bits_next >= (BIT_CNT_W+1)'(FRAME_BITS)) begin
                                n_phase = PH_WAIT_EDGE;
                            end else begin
                                n_bits  = bits_next[BIT_CNT_W-1:0];
                                n_count = '0;
                                if (r_sample_delay == '0) begin
                                    n_shift = shift_base |
                                              bit_mask(bits_next[2:0], lvl);
                                    n_pend  = lvl ? 2'd1 : 2'd2;
                                    n_phase = PH_EDGES;
                                end else begin
                                    n_phase = PH_DELAY;
                                end
                            end
                        end
                    end
                end
                default: begin
                    n_phase = PH_INIT;
                end
            endcase
        end
    end

    // Hold configuration, take writes at once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quiet_len    <= QUIET_RST;
            r_sample_delay <= DELAY_RST;
            r_skip_len     <= SKIP_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_QUIET_LEN:    r_quiet_len    <= i_cfg_data[QUIET_W-1:0];
                CFG_SAMPLE_DELAY: r_sample_delay <= i_cfg_data[DELAY_W-1:0];
                CFG_SKIP_LEN:     r_skip_len     <= i_cfg_data[SKIP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Advance sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_INIT;
            r_count <= '0;
            r_ewin  <= 1'b0;
            r_pend  <= '0;
            r_shift <= '0;
            r_bits  <= '0;
        end else begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_ewin  <= n_ewin;
            r_pend  <= n_pend;
            r_shift <= n_shift;
            r_bits  <= n_bits;
        end
    end

    // Result register: load on emit, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_data_byte  <= r_shift;
            r_byte_index <= r_bits[BIT_CNT_W-1:3];
            r_last_byte  <= (bits_plus9 > (BIT_CNT_W+2)'(FRAME_BITS));
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_data_byte  = r_data_byte;
    assign o_byte_index = r_byte_index;
    assign o_last_byte  = r_last_byte;

endmodule

/* rtl/pulse_width_frame_decoder_core.sv */
// Pulse-width frame decoder: takes one line sample per item and emits the
// decoded bytes of a single-wire frame, first received bit in bit 7, with the
// byte's position and a flag on the final byte. A sample is accepted every
// cycle while the four-entry sample queue has room; the sequencer retires one
// queued sample per cycle unless a finished byte is held by output stall.
// A finished byte is registered as its last sample retires. Configuration
// writes are always ready and take effect on the next sample processed.
module pulse_width_frame_decoder_core
    import pwfd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_line_level,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [7:0]            o_data_byte,
    output logic [IDX_W-1:0]      o_byte_index,
    output logic                  o_last_byte
);

    logic      push;
    logic      pop;
    t_sample   front_item;
    t_sample   queue_item;
    t_q_status q_status;

    assign o_cfg_ready = 1'b1;

    pwfd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_in_valid),
        .i_level    (i_line_level),
        .i_q_status (q_status),
        .o_push     (push),
        .o_item     (front_item),
        .o_stall    (o_in_stall)
    );

    pwfd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (front_item),
        .i_pop    (pop),
        .o_item   (queue_item),
        .o_status (q_status)
    );

    pwfd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (queue_item),
        .i_q_status   (q_status),
        .o_pop        (pop),
        .i_cfg_valid  (i_cfg_valid && o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_data_byte  (o_data_byte),
        .o_byte_index (o_byte_index),
        .o_last_byte  (o_last_byte)
    );

`ifndef SYNTHESIS
    // Never retire a sample from an empty queue
    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_status.empty)
        else $error("sample retired from empty queue");

    // An accepted sample is in the queue on the next cycle
    a_push_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |=> !q_status.empty)
        else $error("accepted sample lost");

    // A new byte only follows a retired sample
    a_out_after_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(pop))
        else $error("byte emitted without a sample");

    // Queue is never both full and empty
    a_queue_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_status.full && q_status.empty))
        else $error("queue status inconsistent");
`endif

endmodule

/* verif/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pwfd_pkg::*;

    // Cycles to let the sample queue and the byte pipeline drain
    localparam int SETTLE_CYCLES = 16;
    localparam int TOTAL_SAMPLES = 1830;
    localparam int PHASE_SAMPLES = 250;

    // Index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef enum logic [2:0] {
        PH_INIT,
        PH_INIT_FALL,
        PH_WAIT_EDGE,
        PH_WINDOW,
        PH_SKIP,
        PH_START_FALL,
        PH_DELAY,
        PH_EDGES
    } t_dec_phase;

    typedef struct packed {
        logic [7:0]       data;
        logic [IDX_W-1:0] pos;
        logic             last;
    } t_frame_byte;

    // Decoder state mirror and the bytes it still owes
    class byte_scoreboard;
        logic [QUIET_W-1:0] quiet_len;
        logic [DELAY_W-1:0] sample_delay;
        logic [SKIP_W-1:0]  skip_len;

        t_dec_phase         ph;
        logic [COUNT_W-1:0] cnt;
        logic               prev_lvl;
        logic               disturbed;
        logic [1:0]         edges_left;
        logic [7:0]         shreg;
        logic [7:0]         bit_no;

        t_frame_byte        owed_bytes[$];
        int                 n_samples;
        int                 n_bytes;
        int                 n_frames;
        int                 n_writes;
        int                 errors;

        function new();
            quiet_len    = QUIET_RST;
            sample_delay = DELAY_RST;
            skip_len     = SKIP_RST;
            ph           = PH_INIT;
            cnt          = '0;
            prev_lvl     = 1'b0;
            disturbed    = 1'b0;
            edges_left   = '0;
            shreg        = '0;
            bit_no       = '0;
            n_samples    = 0;
            n_bytes      = 0;
            n_frames     = 0;
            n_writes     = 0;
            errors       = 0;
        endfunction

        function int pending();
            return owed_bytes.size();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            n_writes++;
            case (idx)
                CFG_QUIET_LEN:    quiet_len    = val[QUIET_W-1:0];
                CFG_SAMPLE_DELAY: sample_delay = val[DELAY_W-1:0];
                CFG_SKIP_LEN:     skip_len     = val[SKIP_W-1:0];
                default: ;
            endcase
        endfunction

        function void start_skip();
            if (skip_len == 0) begin
                ph = PH_WAIT_EDGE;
            end else begin
                ph  = PH_SKIP;
                cnt = '0;
            end
        endfunction

        function void close_window(logic lvl);
            if (disturbed)
                start_skip();
            else if (lvl)
                ph = PH_START_FALL;
            else
                ph = PH_WAIT_EDGE;
        endfunction

        function void open_window(logic lvl);
            cnt       = '0;
            disturbed = 1'b0;
            if (quiet_len == 0)
                close_window(lvl);
            else
                ph = PH_WINDOW;
        endfunction

        // Low at the sample point decodes as 1 and owes more line transitions than a high one
        function void take_bit(logic lvl);
            if (!lvl) begin
                shreg      = shreg | (8'h80 >> bit_no[2:0]);
                edges_left = 2'd2;
            end else begin
                edges_left = 2'd1;
            end
            ph = PH_EDGES;
        endfunction

        function void begin_bit(logic lvl);
            cnt = '0;
            if (sample_delay == 0)
                take_bit(lvl);
            else
                ph = PH_DELAY;
        endfunction

        // Advance the decoder by one accepted line sample
        function void note_sample(logic lvl);
            logic        toggled;
            t_frame_byte fb;
            toggled = (lvl != prev_lvl);
            n_samples++;
            case (ph)
                PH_INIT: begin
                    ph = lvl ? PH_INIT_FALL : PH_WAIT_EDGE;
                end
                PH_INIT_FALL: begin
                    if (toggled)
                        ph = PH_WAIT_EDGE;
                end
                PH_WAIT_EDGE: begin
                    if (toggled)
                        open_window(lvl);
                end
                PH_WINDOW: begin
                    cnt = cnt + 1'b1;
                    if (toggled)
                        disturbed = 1'b1;
                    if (cnt >= quiet_len)
                        close_window(lvl);
                end
                PH_SKIP: begin
                    cnt = cnt + 1'b1;
                    if (cnt >= skip_len)
                        ph = PH_WAIT_EDGE;
                end
                PH_START_FALL: begin
                    if (toggled) begin
                        bit_no = '0;
                        shreg  = '0;
                        begin_bit(lvl);
                    end
                end
                PH_DELAY: begin
                    cnt = cnt + 1'b1;
                    if (cnt >= COUNT_W'(sample_delay))
                        take_bit(lvl);
                end
                default: begin
                    if (toggled && edges_left != 0) begin
                        edges_left = edges_left - 1'b1;
                        if (edges_left == 0) begin
                            if (bit_no[2:0] == 3'd7) begin
                                fb.data = shreg;
                                fb.pos  = bit_no[7:3];
                                fb.last = (int'(bit_no) + 9 > FRAME_BITS);
                                owed_bytes.push_back(fb);
                                shreg = '0;
                            end
                            if (int'(bit_no) + 1 >= FRAME_BITS) begin
                                ph = PH_WAIT_EDGE;
                            end else begin
                                bit_no = bit_no + 1'b1;
                                begin_bit(lvl);
                            end
                        end
                    end
                end
            endcase
            prev_lvl = lvl;
        endfunction

        function void report(string what, int unsigned exp_v, int unsigned got_v);
            errors++;
            $display("%0t: %s expected %0h got %0h", $time, what, exp_v, got_v);
        endfunction

        // Compare one emitted byte with the oldest one owed
        function void check_byte(logic [7:0] data, logic [IDX_W-1:0] pos, logic last);
            t_frame_byte fb;
            if (owed_bytes.size() == 0) begin
                errors++;
                $display("%0t: unexpected byte %02h index %0d last %0b",
                         $time, data, pos, last);
                return;
            end
            fb = owed_bytes.pop_front();
            n_bytes++;
            if (last)
                n_frames++;
            if (data !== fb.data)
                report("data_byte", fb.data, data);
            if (pos !== fb.pos)
                report("byte_index", fb.pos, pos);
            if (last !== fb.last)
                report("last_byte", fb.last, last);
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n      = 1'b0;
    logic                  i_in_valid   = 1'b0;
    logic                  i_line_level = 1'b0;
    logic                  i_cfg_valid  = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data   = '0;
    logic                  i_out_stall  = 1'b0;
    logic                  o_in_stall;
    logic                  o_cfg_ready;
    logic                  o_out_valid;
    logic [7:0]            o_data_byte;
    logic [IDX_W-1:0]      o_byte_index;
    logic                  o_last_byte;

    bit             idle_on = 1'b1;
    byte_scoreboard sb      = new();

    pulse_width_frame_decoder_core uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_line_level (i_line_level),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_data_byte  (o_data_byte),
        .o_byte_index (o_byte_index),
        .o_last_byte  (o_last_byte)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Check emitted bytes and stall the output at random
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_byte(o_data_byte, o_byte_index, o_last_byte);
        i_out_stall <= idle_on && ($urandom_range(0, 99) < 20);
    end

    // Push one line sample, with random idle cycles ahead of it
    task automatic send_level(input logic lvl);
        while (idle_on && $urandom_range(0, 99) < 20) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_line_level <= lvl;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        sb.note_sample(lvl);
    endtask

    task automatic send_noise(input int n);
        repeat (n)
            send_level(1'($urandom_range(0, 1)));
    endtask

    // Drop valid and let every owed byte and queued sample go through
    task automatic drain_samples();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES)
            @(posedge i_clk);
    endtask

    // Write one register; hold valid when another write follows
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val, input bit more);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        if (!more)
            i_cfg_valid <= 1'b0;
        sb.write_reg(idx, val);
    endtask

    task automatic set_cfg(input int quiet, input int delay, input int skip);
        drain_samples();
        write_reg(CFG_QUIET_LEN, CFG_DATA_W'(quiet), 1'b1);
        write_reg(CFG_SAMPLE_DELAY, CFG_DATA_W'(delay), 1'b1);
        write_reg(CFG_SKIP_LEN, CFG_DATA_W'(skip), 1'b0);
    endtask

    // Steer the line until the decoder waits for an edge with the line low
    task automatic resync_line();
        while (!(sb.ph == PH_WAIT_EDGE && sb.prev_lvl == 1'b0)) begin
            case (sb.ph)
                PH_INIT_FALL, PH_START_FALL, PH_EDGES: send_level(!sb.prev_lvl);
                PH_WAIT_EDGE: send_level(1'b0);
                default: send_level(sb.prev_lvl);
            endcase
        end
    endtask

    // Send a start window and nb bits; a glitch breaks the quiet window instead
    task automatic send_frame(input int nb, input bit glitch);
        int         hi;
        int         r;
        logic [7:0] pattern;
        bit         b;
        pattern = '0;
        resync_line();
        if (glitch && sb.quiet_len != 0) begin
            hi = $urandom_range(1, (sb.quiet_len > 8) ? 8 : int'(sb.quiet_len));
            repeat (hi)
                send_level(1'b1);
            send_level(1'b0);
            return;
        end
        repeat (1 + int'(sb.quiet_len) + $urandom_range(0, 2))
            send_level(1'b1);
        for (int i = 0; i < nb; i++) begin
            if (i % 8 == 0) begin
                case ($urandom_range(0, 5))
                    0: pattern = 8'h00;
                    1: pattern = 8'hFF;
                    default: pattern = 8'($urandom);
                endcase
            end
            b = pattern[7 - i % 8] || (sb.sample_delay == 0);
            send_level(1'b0);
            if (b) begin
                repeat (int'(sb.sample_delay) + $urandom_range(0, 1))
                    send_level(1'b0);
                repeat (1 + $urandom_range(0, 1))
                    send_level(1'b1);
            end else begin
                r = $urandom_range(0, int'(sb.sample_delay) - 1);
                repeat (r)
                    send_level(1'b0);
                repeat (int'(sb.sample_delay) - r + $urandom_range(0, 1))
                    send_level(1'b1);
            end
        end
        if (nb == FRAME_BITS) begin
            repeat (1 + $urandom_range(0, 2))
                send_level(1'b0);
        end
    endtask

    initial begin
        int budget;
        int pick;

        repeat (2)
            @(posedge i_clk);
        i_rst_n <= 1'b1;

        // High first sample: wait for the falling edge
        send_level(1'b1);
        send_level(1'b1);
        send_level(1'b0);

        // Masked delay write and a write to the unused index
        drain_samples();
        write_reg(CFG_QUIET_LEN, 24'd2, 1'b1);
        write_reg(CFG_SAMPLE_DELAY, 24'hFF0001, 1'b1);
        write_reg(CFG_SKIP_LEN, 24'd5, 1'b1);
        write_reg(CFG_UNUSED, 24'hA5A5A5, 1'b0);

        // Disturbed window into skip, then shrink skip below the count
        send_level(1'b1);
        send_level(1'b0);
        send_level(1'b0);
        repeat (3)
            send_level(1'b0);
        drain_samples();
        write_reg(CFG_SKIP_LEN, 24'd1, 1'b0);
        send_level(1'b0);

        // Shrink the quiet window to the running count
        send_level(1'b1);
        send_level(1'b1);
        drain_samples();
        write_reg(CFG_QUIET_LEN, 24'd1, 1'b0);
        send_level(1'b1);
        send_level(1'b0);
        send_level(1'b0);

        // All registers at their maximum for a short burst
        set_cfg(24'hFFFFFF, 16'hFFFF, 24'hFFFFFF);
        send_noise(10);

        // Random frames under a rotating set of timings
        for (int s = 0; sb.n_samples < TOTAL_SAMPLES; s++) begin
            case (s)
                0: set_cfg(3, 2, 6);
                1: set_cfg(1, 1, 0);
                2: set_cfg(0, 0, 2);
                3: set_cfg(5, 4, 12);
                4: set_cfg(2, 3, 1);
                5: set_cfg(4, 1, 3);
                default: set_cfg($urandom_range(0, 6), $urandom_range(0, 5),
                                 $urandom_range(0, 15));
            endcase
            idle_on = (s != 3);
            budget  = sb.n_samples + PHASE_SAMPLES;
            while (sb.n_samples < budget && sb.n_samples < TOTAL_SAMPLES) begin
                pick = $urandom_range(0, 9);
                if (pick < 7)
                    send_frame(FRAME_BITS, 1'b0);
                else if (pick == 7)
                    send_frame($urandom_range(1, FRAME_BITS - 1), 1'b0);
                else if (pick == 8)
                    send_frame(0, 1'b1);
                else
                    send_noise($urandom_range(1, 20));
            end
        end
        idle_on = 1'b1;

        drain_samples();
        $display("Decoded %0d line samples into %0d bytes (%0d full frames)",
                 sb.n_samples, sb.n_bytes, sb.n_frames);
        $display("Applied %0d register writes across zero, small and maximum timings",
                 sb.n_writes);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Hang guard
    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

/* pulse_width_frame_decoder_core.f */
rtl/pwfd_pkg.sv
rtl/pwfd_front.sv
rtl/pwfd_queue.sv
rtl/pwfd_back.sv
rtl/pulse_width_frame_decoder_core.sv
verif/testbench.sv
